>>> hw/rtl/fcgird_pkg.sv
// Shared types and constants for the FastCGI record deframer.
`timescale 1ns / 1ps
`default_nettype none

package fcgird_pkg;

  localparam logic [7:0] TYPE_PARAMS = 8'd4;
  localparam logic [7:0] TYPE_STDIN  = 8'd5;

  localparam logic [6:0] LEN_LOW_MASK = 7'h7f;
  localparam int unsigned LEN_SHIFT_HI  = 24;
  localparam int unsigned LEN_SHIFT_MID = 16;

  // Header byte positions
  localparam logic [2:0] HDR_VERSION = 3'd0;
  localparam logic [2:0] HDR_TYPE    = 3'd1;
  localparam logic [2:0] HDR_ID_HI   = 3'd2;
  localparam logic [2:0] HDR_ID_LO   = 3'd3;
  localparam logic [2:0] HDR_LEN_HI  = 3'd4;
  localparam logic [2:0] HDR_LEN_LO  = 3'd5;
  localparam logic [2:0] HDR_PAD     = 3'd6;
  localparam logic [2:0] HDR_RSVD    = 3'd7;

  // Length byte positions within a long pair length
  localparam logic [1:0] LB_FIRST  = 2'd0;
  localparam logic [1:0] LB_SECOND = 2'd1;
  localparam logic [1:0] LB_THIRD  = 2'd2;
  localparam logic [1:0] LB_LAST   = 2'd3;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_PADDING  = 3'd1,
    KIND_SKIPPED  = 3'd2,
    KIND_PAIR_LEN = 3'd3,
    KIND_NAME     = 3'd4,
    KIND_VALUE    = 3'd5,
    KIND_BODY     = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    PH_NAME_LEN  = 3'd0,
    PH_VALUE_LEN = 3'd1,
    PH_NAME      = 3'd2,
    PH_VALUE     = 3'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  len_idx;
    logic [30:0] name_cnt;
    logic [30:0] value_cnt;
    logic        discard;
  } pair_state_t;

  localparam pair_state_t PAIR_CLEAR = '{
    phase:     PH_NAME_LEN,
    len_idx:   LB_FIRST,
    name_cnt:  31'd0,
    value_cnt: 31'd0,
    discard:   1'b0
  };

  typedef struct packed {
    kind_t       byte_kind;
    logic [7:0]  data_byte;
    logic [7:0]  record_kind;
    logic [15:0] current_request;
    logic        pair_complete;
    logic        pair_overrun;
    logic        record_end;
    logic        request_done;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/fcgird_if.sv
// Valid/ready channel interfaces for the deframer input and result streams.
`timescale 1ns / 1ps
`default_nettype none

interface fcgird_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface fcgird_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_kind;
  logic [7:0]  data_byte;
  logic [7:0]  record_kind;
  logic [15:0] current_request;
  logic        pair_complete;
  logic        pair_overrun;
  logic        record_end;
  logic        request_done;

  modport source (
    output valid, output byte_kind, output data_byte, output record_kind,
    output current_request, output pair_complete, output pair_overrun,
    output record_end, output request_done, input ready
  );
  modport sink (
    input valid, input byte_kind, input data_byte, input record_kind,
    input current_request, input pair_complete, input pair_overrun,
    input record_end, input request_done, output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/fcgird_pair_parse.sv
// Name-value pair length decode and pair tracking for one PARAMS content byte.
`timescale 1ns / 1ps
`default_nettype none

module fcgird_pair_parse (
  input  wire logic [7:0]           data_byte,
  input  wire logic [15:0]          rem,       // content bytes left after this one
  input  wire fcgird_pkg::pair_state_t cur,
  output fcgird_pkg::pair_state_t   nxt,
  output fcgird_pkg::kind_t         kind,
  output logic                      pair_complete,
  output logic                      pair_overrun
);

  logic [30:0] acc;
  logic [30:0] name_dec;
  logic [30:0] value_dec;
  logic [31:0] len_sum;
  logic        len_done;
  logic        cut_short;

  always_comb begin
    nxt           = cur;
    kind          = fcgird_pkg::KIND_PAIR_LEN;
    pair_complete = 1'b0;
    pair_overrun  = 1'b0;
    len_done      = 1'b0;
    cut_short     = 1'b0;
    name_dec  = (cur.name_cnt != 31'd0) ? cur.name_cnt - 31'd1 : cur.name_cnt;
    value_dec = (cur.value_cnt != 31'd0) ? cur.value_cnt - 31'd1 : cur.value_cnt;
    acc = (cur.phase == fcgird_pkg::PH_NAME_LEN) ? cur.name_cnt : cur.value_cnt;
    len_sum = 32'd0;

    unique case (cur.len_idx)
      fcgird_pkg::LB_FIRST: begin
        if (data_byte[7]) begin
          if (rem < 16'd3) begin
            cut_short = 1'b1;
          end else begin
            acc = 31'(data_byte[6:0] & fcgird_pkg::LEN_LOW_MASK) << fcgird_pkg::LEN_SHIFT_HI;
            nxt.len_idx = fcgird_pkg::LB_SECOND;
          end
        end else begin
          acc = {23'd0, data_byte};
          len_done = 1'b1;
        end
      end
      fcgird_pkg::LB_SECOND: begin
        acc = acc | (31'(data_byte) << fcgird_pkg::LEN_SHIFT_MID);
        nxt.len_idx = fcgird_pkg::LB_THIRD;
      end
      fcgird_pkg::LB_THIRD: begin
        acc = acc | {15'd0, data_byte, 8'd0};
        nxt.len_idx = fcgird_pkg::LB_LAST;
      end
      fcgird_pkg::LB_LAST: begin
        acc = acc | {23'd0, data_byte};
        nxt.len_idx = fcgird_pkg::LB_FIRST;
        len_done = 1'b1;
      end
    endcase

    if (cur.discard) begin
      nxt  = cur;
      kind = fcgird_pkg::KIND_SKIPPED;
    end else begin
      unique case (cur.phase)
        fcgird_pkg::PH_NAME: begin
          nxt.len_idx  = cur.len_idx;
          nxt.name_cnt = name_dec;
          kind         = fcgird_pkg::KIND_NAME;
          if (name_dec == 31'd0) begin
            if (cur.value_cnt != 31'd0) begin
              nxt.phase = fcgird_pkg::PH_VALUE;
            end else begin
              pair_complete = 1'b1;
              nxt.phase     = fcgird_pkg::PH_NAME_LEN;
            end
          end
        end
        fcgird_pkg::PH_VALUE: begin
          nxt.len_idx   = cur.len_idx;
          nxt.value_cnt = value_dec;
          kind          = fcgird_pkg::KIND_VALUE;
          if (value_dec == 31'd0) begin
            pair_complete = 1'b1;
            nxt.phase     = fcgird_pkg::PH_NAME_LEN;
          end
        end
        fcgird_pkg::PH_NAME_LEN: begin
          if (cut_short) begin
            nxt.len_idx  = cur.len_idx;
            pair_overrun = 1'b1;
            nxt.discard  = 1'b1;
          end else begin
            nxt.name_cnt = acc;
            if (len_done) begin
              nxt.phase     = fcgird_pkg::PH_VALUE_LEN;
              nxt.value_cnt = 31'd0;
              if (rem == 16'd0) begin
                pair_overrun = 1'b1;
                nxt.discard  = 1'b1;
              end
            end
          end
        end
        fcgird_pkg::PH_VALUE_LEN: begin
          if (cut_short) begin
            nxt.len_idx  = cur.len_idx;
            pair_overrun = 1'b1;
            nxt.discard  = 1'b1;
          end else begin
            nxt.value_cnt = acc;
            len_sum = {1'b0, cur.name_cnt} + {1'b0, acc};
            if (len_done) begin
              if (len_sum > {16'd0, rem}) begin
                pair_overrun = 1'b1;
                nxt.discard  = 1'b1;
              end else if (cur.name_cnt != 31'd0) begin
                nxt.phase = fcgird_pkg::PH_NAME;
              end else if (acc != 31'd0) begin
                nxt.phase = fcgird_pkg::PH_VALUE;
              end else begin
                pair_complete = 1'b1;
                nxt.phase     = fcgird_pkg::PH_NAME_LEN;
              end
            end
          end
        end
        default: begin
          nxt         = cur;
          nxt.discard = 1'b1;
          kind        = fcgird_pkg::KIND_SKIPPED;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fastcgi_record_deframer_core.sv
// FastCGI record deframer top level: byte tagging, record and request tracking.
//
//   channel  | dir | handshake     | transaction
//   ---------+-----+---------------+------------------------------------------
//   in_ch    | in  | valid/ready   | one stream byte
//   out_ch   | out | valid/ready   | byte tag, record type, request id, flags
//
// One byte per cycle sustained while out_ch.ready is high; each result appears in
// the cycle after its byte is taken, from a single output register.
// The parser state advances on the accepting edge; the whole per-byte update
// (header fields, content and padding counters, pair length decode with the
// 32-bit length check) is one combinational pass.
// in_ch.ready stays high while the output register is empty or being drained.
// Synchronous active-low reset clears all parser state and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module fastcgi_record_deframer_core (
  input  wire logic     clk,
  input  wire logic     rst_n,
  fcgird_in_if.sink     in_ch,
  fcgird_out_if.source  out_ch
);

  logic [2:0]  hdr_idx_r,    hdr_idx_nxt;
  logic [7:0]  rec_type_r,   rec_type_nxt;
  logic [15:0] content_r,    content_nxt;
  logic [7:0]  padding_r,    padding_nxt;
  logic [15:0] kept_id_r,    kept_id_nxt;
  logic        params_fin_r, params_fin_nxt;
  logic        stdin_fin_r,  stdin_fin_nxt;
  logic [7:0]  id_high_r,    id_high_nxt;
  logic        rec_empty_r,  rec_empty_nxt;
  fcgird_pkg::pair_state_t pair_r, pair_nxt;

  logic                 out_valid_r;
  fcgird_pkg::result_t  out_data_r;
  fcgird_pkg::result_t  res;

  logic [15:0] content_dec;
  logic [7:0]  padding_dec;
  logic        in_fire;

  fcgird_pkg::pair_state_t pp_nxt;
  fcgird_pkg::kind_t       pp_kind;
  logic                    pp_complete;
  logic                    pp_overrun;

  assign content_dec = content_r - 16'd1;
  assign padding_dec = padding_r - 8'd1;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  fcgird_pair_parse u_pair (
    .data_byte     (in_ch.stream_byte),
    .rem           (content_dec),
    .cur           (pair_r),
    .nxt           (pp_nxt),
    .kind          (pp_kind),
    .pair_complete (pp_complete),
    .pair_overrun  (pp_overrun)
  );

  always_comb begin
    hdr_idx_nxt    = hdr_idx_r;
    rec_type_nxt   = rec_type_r;
    content_nxt    = content_r;
    padding_nxt    = padding_r;
    kept_id_nxt    = kept_id_r;
    params_fin_nxt = params_fin_r;
    stdin_fin_nxt  = stdin_fin_r;
    id_high_nxt    = id_high_r;
    rec_empty_nxt  = rec_empty_r;
    pair_nxt       = pair_r;

    res.byte_kind       = fcgird_pkg::KIND_HEADER;
    res.data_byte       = in_ch.stream_byte;
    res.pair_complete   = 1'b0;
    res.pair_overrun    = 1'b0;
    res.record_end      = 1'b0;
    res.request_done    = 1'b0;

    priority if (hdr_idx_r != fcgird_pkg::HDR_VERSION ||
                 (content_r == 16'd0 && padding_r == 8'd0)) begin
      res.byte_kind = fcgird_pkg::KIND_HEADER;
      unique case (hdr_idx_r)
        fcgird_pkg::HDR_VERSION: ;
        fcgird_pkg::HDR_TYPE:    rec_type_nxt = in_ch.stream_byte;
        fcgird_pkg::HDR_ID_HI:   id_high_nxt  = in_ch.stream_byte;
        fcgird_pkg::HDR_ID_LO: begin
          if (kept_id_r == 16'd0) kept_id_nxt = {id_high_r, in_ch.stream_byte};
        end
        fcgird_pkg::HDR_LEN_HI:  content_nxt = {in_ch.stream_byte, 8'd0};
        fcgird_pkg::HDR_LEN_LO:  content_nxt = content_r | {8'd0, in_ch.stream_byte};
        fcgird_pkg::HDR_PAD:     padding_nxt = in_ch.stream_byte;
        fcgird_pkg::HDR_RSVD: begin
          pair_nxt      = fcgird_pkg::PAIR_CLEAR;
          rec_empty_nxt = (content_r == 16'd0);
          res.record_end = (content_r == 16'd0) && (padding_r == 8'd0);
        end
      endcase
      hdr_idx_nxt = hdr_idx_r + 3'd1;
    end else if (content_r != 16'd0) begin
      content_nxt = content_dec;
      if (rec_type_r == fcgird_pkg::TYPE_PARAMS) begin
        res.byte_kind     = pp_kind;
        res.pair_complete = pp_complete;
        res.pair_overrun  = pp_overrun;
        pair_nxt          = pp_nxt;
      end else if (rec_type_r == fcgird_pkg::TYPE_STDIN) begin
        res.byte_kind = fcgird_pkg::KIND_BODY;
      end else begin
        res.byte_kind = fcgird_pkg::KIND_SKIPPED;
      end
      res.record_end = (content_dec == 16'd0) && (padding_r == 8'd0);
    end else begin
      res.byte_kind  = fcgird_pkg::KIND_PADDING;
      padding_nxt    = padding_dec;
      res.record_end = (padding_dec == 8'd0);
    end

    if (res.record_end && rec_empty_nxt) begin
      if (rec_type_nxt == fcgird_pkg::TYPE_PARAMS) begin
        params_fin_nxt = 1'b1;
      end else if (rec_type_nxt == fcgird_pkg::TYPE_STDIN) begin
        stdin_fin_nxt = 1'b1;
      end
    end

    res.record_kind     = rec_type_nxt;
    res.current_request = kept_id_nxt;
    res.request_done    = res.record_end && params_fin_nxt && stdin_fin_nxt;

    if (res.request_done) begin
      kept_id_nxt    = 16'd0;
      params_fin_nxt = 1'b0;
      stdin_fin_nxt  = 1'b0;
      pair_nxt       = fcgird_pkg::PAIR_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_idx_r    <= fcgird_pkg::HDR_VERSION;
      rec_type_r   <= 8'd0;
      content_r    <= 16'd0;
      padding_r    <= 8'd0;
      kept_id_r    <= 16'd0;
      params_fin_r <= 1'b0;
      stdin_fin_r  <= 1'b0;
      id_high_r    <= 8'd0;
      rec_empty_r  <= 1'b0;
      pair_r       <= fcgird_pkg::PAIR_CLEAR;
    end else if (in_fire) begin
      hdr_idx_r    <= hdr_idx_nxt;
      rec_type_r   <= rec_type_nxt;
      content_r    <= content_nxt;
      padding_r    <= padding_nxt;
      kept_id_r    <= kept_id_nxt;
      params_fin_r <= params_fin_nxt;
      stdin_fin_r  <= stdin_fin_nxt;
      id_high_r    <= id_high_nxt;
      rec_empty_r  <= rec_empty_nxt;
      pair_r       <= pair_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.byte_kind       = out_data_r.byte_kind;
  assign out_ch.data_byte       = out_data_r.data_byte;
  assign out_ch.record_kind     = out_data_r.record_kind;
  assign out_ch.current_request = out_data_r.current_request;
  assign out_ch.pair_complete   = out_data_r.pair_complete;
  assign out_ch.pair_overrun    = out_data_r.pair_overrun;
  assign out_ch.record_end      = out_data_r.record_end;
  assign out_ch.request_done    = out_data_r.request_done;

endmodule

`default_nettype wire

>>> dv/fastcgi_record_deframer_core_tb.sv
// Self-checking bench for the FastCGI record deframer: byte stream in, byte tags checked out.
`timescale 1ns / 1ps

module fastcgi_record_deframer_core_tb;
  import fcgird_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_BYTES = 600;
  localparam logic [7:0]  TYPE_BEGIN   = 8'd1;

  typedef struct {
    logic [7:0]  b;
    int unsigned gap;
    bit          hold;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  fcgird_in_if  in_bus ();
  fcgird_out_if out_bus ();

  fastcgi_record_deframer_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Deframer state mirror
  logic [2:0]  s_hdr_idx   = '0;
  logic [7:0]  s_type      = '0;
  logic [15:0] s_content   = '0;
  logic [7:0]  s_pad       = '0;
  logic [15:0] s_req_id    = '0;
  logic        s_params_fin = 1'b0;
  logic        s_stdin_fin  = 1'b0;
  logic [7:0]  s_id_hi     = '0;
  logic        s_empty     = 1'b0;
  phase_t      p_phase     = PH_NAME_LEN;
  logic [1:0]  p_len_idx   = LB_FIRST;
  logic [30:0] p_name_cnt  = '0;
  logic [30:0] p_value_cnt = '0;
  logic        p_discard   = 1'b0;

  result_t     tags_due[$];
  stim_t       feed_q[$];
  logic [7:0]  body_q[$];

  int unsigned bytes_in = 0;
  int unsigned tags_out = 0;
  int unsigned bad_cnt  = 0;
  int unsigned cyc      = 0;
  bit          src_calm = 1'b0;
  bit          hold_next = 1'b0;

  function automatic int unsigned pick_wait();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void clear_pairs();
    p_phase     = PH_NAME_LEN;
    p_len_idx   = LB_FIRST;
    p_name_cnt  = '0;
    p_value_cnt = '0;
    p_discard   = 1'b0;
  endfunction

  // One PARAMS content byte; rem is the content left after it.
  function automatic kind_t pair_byte(input logic [7:0] b, input logic [15:0] rem,
                                      output logic pc, output logic ov);
    logic        len_done;
    logic [31:0] acc;
    pc = 1'b0;
    ov = 1'b0;
    len_done = 1'b0;
    if (p_discard) return KIND_SKIPPED;
    case (p_phase)
      PH_NAME: begin
        if (p_name_cnt != 0) p_name_cnt = p_name_cnt - 31'd1;
        if (p_name_cnt == 0) begin
          if (p_value_cnt != 0) begin
            p_phase = PH_VALUE;
          end else begin
            pc = 1'b1;
            p_phase = PH_NAME_LEN;
          end
        end
        return KIND_NAME;
      end
      PH_VALUE: begin
        if (p_value_cnt != 0) p_value_cnt = p_value_cnt - 31'd1;
        if (p_value_cnt == 0) begin
          pc = 1'b1;
          p_phase = PH_NAME_LEN;
        end
        return KIND_VALUE;
      end
      PH_NAME_LEN, PH_VALUE_LEN: ;
      default: begin
        p_discard = 1'b1;
        return KIND_SKIPPED;
      end
    endcase

    acc = (p_phase == PH_NAME_LEN) ? {1'b0, p_name_cnt} : {1'b0, p_value_cnt};
    case (p_len_idx)
      LB_FIRST: begin
        if (b[7]) begin
          if (rem < 16'd3) begin
            ov = 1'b1;
            p_discard = 1'b1;
            return KIND_PAIR_LEN;
          end
          acc = {1'b0, b[6:0], 24'd0};
          p_len_idx = LB_SECOND;
        end else begin
          acc = {24'd0, b};
          len_done = 1'b1;
        end
      end
      LB_SECOND: begin
        acc = acc | {8'd0, b, 16'd0};
        p_len_idx = LB_THIRD;
      end
      LB_THIRD: begin
        acc = acc | {16'd0, b, 8'd0};
        p_len_idx = LB_LAST;
      end
      default: begin
        acc = acc | {24'd0, b};
        p_len_idx = LB_FIRST;
        len_done = 1'b1;
      end
    endcase

    if (p_phase == PH_NAME_LEN) begin
      p_name_cnt = acc[30:0];
      if (len_done) begin
        p_phase = PH_VALUE_LEN;
        p_value_cnt = '0;
        if (rem == 0) begin
          ov = 1'b1;
          p_discard = 1'b1;
        end
      end
    end else begin
      p_value_cnt = acc[30:0];
      if (len_done) begin
        if (({2'b0, p_name_cnt} + {2'b0, p_value_cnt}) > {17'd0, rem}) begin
          ov = 1'b1;
          p_discard = 1'b1;
        end else if (p_name_cnt != 0) begin
          p_phase = PH_NAME;
        end else if (p_value_cnt != 0) begin
          p_phase = PH_VALUE;
        end else begin
          pc = 1'b1;
          p_phase = PH_NAME_LEN;
        end
      end
    end
    return KIND_PAIR_LEN;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    result_t r;
    kind_t   k;
    logic    pc, ov, rend, done;
    k = KIND_HEADER;
    pc = 1'b0;
    ov = 1'b0;
    rend = 1'b0;
    if (s_hdr_idx != 0 || (s_content == 0 && s_pad == 0)) begin
      case (s_hdr_idx)
        HDR_TYPE:   s_type = b;
        HDR_ID_HI:  s_id_hi = b;
        HDR_ID_LO:  if (s_req_id == 0) s_req_id = {s_id_hi, b};
        HDR_LEN_HI: s_content = {b, 8'd0};
        HDR_LEN_LO: s_content = {s_content[15:8], b};
        HDR_PAD:    s_pad = b;
        HDR_RSVD: begin
          clear_pairs();
          s_empty = (s_content == 0);
          if (s_content == 0 && s_pad == 0) rend = 1'b1;
        end
        default: ;
      endcase
      s_hdr_idx = s_hdr_idx + 3'd1;
    end else if (s_content != 0) begin
      s_content = s_content - 16'd1;
      if (s_type == TYPE_PARAMS) k = pair_byte(b, s_content, pc, ov);
      else if (s_type == TYPE_STDIN) k = KIND_BODY;
      else k = KIND_SKIPPED;
      if (s_content == 0 && s_pad == 0) rend = 1'b1;
    end else begin
      k = KIND_PADDING;
      s_pad = s_pad - 8'd1;
      if (s_pad == 0) rend = 1'b1;
    end

    if (rend && s_empty) begin
      if (s_type == TYPE_PARAMS) s_params_fin = 1'b1;
      else if (s_type == TYPE_STDIN) s_stdin_fin = 1'b1;
    end
    done = rend && s_params_fin && s_stdin_fin;

    r.byte_kind       = k;
    r.data_byte       = b;
    r.record_kind     = s_type;
    r.current_request = s_req_id;
    r.pair_complete   = pc;
    r.pair_overrun    = ov;
    r.record_end      = rend;
    r.request_done    = done;
    tags_due.push_back(r);

    if (done) begin
      s_req_id = '0;
      s_params_fin = 1'b0;
      s_stdin_fin = 1'b0;
      clear_pairs();
    end
  endtask

  // Stimulus building
  task automatic put(input logic [7:0] b);
    stim_t s;
    s.b = b;
    s.gap = src_calm ? 0 : pick_wait();
    s.hold = hold_next;
    hold_next = 1'b0;
    feed_q.push_back(s);
  endtask

  task automatic put_record(input logic [7:0] ver, input logic [7:0] typ,
                            input logic [15:0] id, input logic [7:0] pad,
                            input logic [7:0] rsvd);
    logic [15:0] clen;
    clen = 16'(body_q.size());
    put(ver);
    put(typ);
    put(id[15:8]);
    put(id[7:0]);
    put(clen[15:8]);
    put(clen[7:0]);
    put(pad);
    put(rsvd);
    foreach (body_q[i]) put(body_q[i]);
    repeat (pad) put(any_byte());
    body_q.delete();
  endtask

  task automatic fill_random(input int unsigned n);
    body_q.delete();
    repeat (n) body_q.push_back(any_byte());
  endtask

  task automatic push_len(input logic [31:0] len, input bit long_form);
    if (long_form || len > 32'd127) begin
      body_q.push_back({1'b1, len[30:24]});
      body_q.push_back(len[23:16]);
      body_q.push_back(len[15:8]);
      body_q.push_back(len[7:0]);
    end else begin
      body_q.push_back(len[7:0]);
    end
  endtask

  task automatic fill_params(input int unsigned pairs, input bit broken);
    logic [31:0] nl, vl;
    int unsigned base, keep;
    body_q.delete();
    repeat (pairs) begin
      nl = $urandom_range(0, 5);
      vl = $urandom_range(0, 5);
      push_len(nl, $urandom_range(0, 3) == 0);
      push_len(vl, $urandom_range(0, 3) == 0);
      repeat (nl + vl) body_q.push_back(any_byte());
    end
    if (broken) begin
      base = body_q.size();
      if ($urandom_range(0, 1) == 1) begin
        nl = $urandom & 32'h7fff_ffff;
        vl = $urandom & 32'h7fff_ffff;
        push_len(nl, 1'b1);
        push_len(vl, 1'b1);
      end else begin
        nl = $urandom_range(1, 6);
        vl = $urandom_range(0, 6);
        push_len(nl, $urandom_range(0, 1) == 1);
        push_len(vl, $urandom_range(0, 1) == 1);
        repeat (nl + vl) body_q.push_back(any_byte());
      end
      keep = $urandom_range(base + 1, body_q.size());
      while (body_q.size() > keep) void'(body_q.pop_back());
    end
  endtask

  function automatic logic [7:0] small_pad();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 7)) : 8'd0;
  endfunction

  task automatic put_request(input int unsigned idx);
    logic [15:0] id;
    logic [7:0]  typ;
    bit          late_stdin;
    id = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
    hold_next = (idx % 5 == 0);
    src_calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 1) begin
      fill_random(8);
      put_record(any_byte(), TYPE_BEGIN, id, small_pad(), any_byte());
    end
    repeat ($urandom_range(0, 3)) begin
      fill_params($urandom_range(0, 3), $urandom_range(0, 2) == 0);
      put_record(any_byte(), TYPE_PARAMS,
                 ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : id,
                 small_pad(), any_byte());
    end
    if (idx == 3 || $urandom_range(0, 3) == 0) begin
      typ = any_byte();
      if (typ == TYPE_PARAMS || typ == TYPE_STDIN) typ = typ ^ 8'h80;
      fill_random((idx == 3) ? 256 + $urandom_range(0, 3) : $urandom_range(0, 6));
      put_record(any_byte(), typ, id, small_pad(), any_byte());
    end
    late_stdin = ($urandom_range(0, 3) != 0);
    if (!late_stdin) put_record(any_byte(), TYPE_STDIN, id, small_pad(), any_byte());
    put_record(any_byte(), TYPE_PARAMS, id, small_pad(), any_byte());
    repeat ($urandom_range(0, 2)) begin
      fill_random($urandom_range(1, 8));
      put_record(any_byte(), TYPE_STDIN, id, small_pad(), any_byte());
    end
    if (late_stdin) put_record(any_byte(), TYPE_STDIN, id, small_pad(), any_byte());
  endtask

  // Driver
  stim_t       nxt;
  bit          have_nxt = 1'b0;
  int unsigned gap_left = 0;
  int unsigned acc_total;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.stream_byte <= 8'd0;
    end else begin
      acc_total = bytes_in;
      if (in_bus.valid && in_bus.ready) begin
        deframe_byte(in_bus.stream_byte);
        acc_total = bytes_in + 1;
        bytes_in <= acc_total;
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (!have_nxt && feed_q.size() != 0) begin
          nxt = feed_q.pop_front();
          have_nxt = 1'b1;
          gap_left = nxt.gap;
        end
        if (have_nxt && gap_left == 0 && (!nxt.hold || tags_out == acc_total)) begin
          in_bus.valid <= 1'b1;
          in_bus.stream_byte <= nxt.b;
          have_nxt = 1'b0;
        end else begin
          in_bus.valid <= 1'b0;
          if (have_nxt && gap_left != 0) gap_left = gap_left - 1;
        end
      end
    end
  end

  // Monitor
  result_t     got, want;
  int unsigned stall_left = 0;
  bit          sink_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.byte_kind       = kind_t'(out_bus.byte_kind);
        got.data_byte       = out_bus.data_byte;
        got.record_kind     = out_bus.record_kind;
        got.current_request = out_bus.current_request;
        got.pair_complete   = out_bus.pair_complete;
        got.pair_overrun    = out_bus.pair_overrun;
        got.record_end      = out_bus.record_end;
        got.request_done    = out_bus.request_done;
        tags_out <= tags_out + 1;
        if (tags_due.size() == 0) begin
          $display("%0t: unexpected transaction kind=%0d byte=%02h", $time,
                   got.byte_kind, got.data_byte);
          bad_cnt++;
        end else begin
          want = tags_due.pop_front();
          if (got !== want) begin
            $display({"%0t: tag mismatch exp kind=%0d byte=%02h type=%02h req=%04h ",
                      "pc=%b ov=%b end=%b done=%b | got kind=%0d byte=%02h type=%02h ",
                      "req=%04h pc=%b ov=%b end=%b done=%b"}, $time,
                     want.byte_kind, want.data_byte, want.record_kind, want.current_request,
                     want.pair_complete, want.pair_overrun, want.record_end,
                     want.request_done,
                     got.byte_kind, got.data_byte, got.record_kind, got.current_request,
                     got.pair_complete, got.pair_overrun, got.record_end, got.request_done);
            bad_cnt++;
          end
        end
        if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
        stall_left = sink_calm ? 0 : pick_wait();
      end
      if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d bytes in, %0d tags out", $time, bytes_in, tags_out);
      $display("end of test: mismatches");
      $finish;
    end
  end

  int unsigned total;
  int unsigned directed;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.stream_byte = 8'd0;
    out_bus.ready = 1'b0;

    // BEGIN_REQUEST with id zero and odd version / reserved bytes
    body_q.push_back(8'h00);
    put_record(8'hff, TYPE_BEGIN, 16'h0000, 8'd0, 8'hff);
    // PARAMS: empty pair, then a long length with no room left
    body_q = '{8'h00, 8'h00, 8'h80};
    put_record(8'h01, TYPE_PARAMS, 16'hffff, 8'd1, 8'h00);
    put_record(8'h01, TYPE_PARAMS, 16'h1234, 8'd0, 8'h00);
    put_record(8'h01, TYPE_STDIN, 16'h0000, 8'd2, 8'h00);
    directed = feed_q.size();

    for (int unsigned idx = 0; feed_q.size() < directed + RANDOM_BYTES; idx++)
      put_request(idx);
    total = feed_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_in != total || tags_out != total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tags_due.size() != 0) begin
      $display("%0t: %0d tags never came out", $time, tags_due.size());
      bad_cnt += tags_due.size();
    end
    if (bad_cnt == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/fcgird_pkg.sv
hw/rtl/fcgird_if.sv
hw/rtl/fcgird_pair_parse.sv
hw/rtl/fastcgi_record_deframer_core.sv
dv/fastcgi_record_deframer_core_tb.sv
